// ===== src/tmq_pkg.sv =====
package tmq_pkg;

  // Request codes carried in req_type.
  typedef enum logic [1:0] {
    REQ_SEND  = 2'd0,
    REQ_RECV  = 2'd1,
    REQ_FLUSH = 2'd2
  } req_e;

  // Result status codes.
  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_INVALID = 3'd1,
    STS_AGAIN   = 3'd2,
    STS_NOMSG   = 3'd3,
    STS_TOOBIG  = 3'd4
  } status_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_BYTE_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MESSAGE_SIZE = 1'b1;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration reset values.
  localparam logic [15:0] QUEUE_BYTE_LIMIT_RST = 16'd16384;
  localparam logic [13:0] MAX_MESSAGE_SIZE_RST = 14'd8192;

  // One request item.
  typedef struct packed {
    logic [1:0]         req_type;
    logic [30:0]        send_type;
    logic signed [31:0] want_type;
    logic [15:0]        msg_size;
    logic               allow_truncate;
    logic [15:0]        payload_handle;
  } req_t;

  // One result item.
  typedef struct packed {
    status_e     status;
    logic [30:0] out_type;
    logic [13:0] out_size;
    logic [15:0] out_handle;
    logic [4:0]  queue_count;
    logic [15:0] queue_bytes;
  } rsp_t;

  // One stored message.
  typedef struct packed {
    logic [30:0] msg_type;
    logic [13:0] size;
    logic [15:0] handle;
  } entry_t;

  // Controller state.
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_EXEC,
    CS_SCAN,
    CS_DECIDE,
    CS_SHIFT,
    CS_DONE
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic exec;
    logic scan;
    logic decide;
    logic shift;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic recv_scan;
    logic scan_done;
    logic shift_go;
    logic shift_done;
  } dp_sts_t;

endpackage

// ===== src/typed_message_queue_core.sv =====
// Typed message queue holding up to QUEUE_DEPTH messages (type, size, handle)
// in arrival order. Each request item yields one result item. A send or flush
// goes from execution straight to the result register. A receive also scans
// and decides: the message store has one registered read port, so the scan
// reads one entry per cycle (k entries, up to the queue count, and all of
// them for a negative selector), and compaction after a removal moves one
// entry per cycle (m, the number of entries behind the removed one). The next
// item is accepted as soon as the result is in the output register, before
// it is taken.
module typed_message_queue_core #(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned MAX_MSG_BYTES = 8192
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tmq_pkg::req_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tmq_pkg::rsp_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [tmq_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [tmq_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  tmq_pkg::ctrl_cmd_t cmd;
  tmq_pkg::dp_sts_t   sts;

  // Sequencer for request handling.
  tmq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Message store, counters and result logic.
  tmq_datapath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .MAX_MSG_BYTES (MAX_MSG_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== src/tmq_ctrl.sv =====
module tmq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  tmq_pkg::dp_sts_t    sts_i,
  output tmq_pkg::ctrl_cmd_t  cmd_o
);

  tmq_pkg::ctrl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;

  // The output register can take a new item when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  // State and output-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tmq_pkg::CS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      tmq_pkg::CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = tmq_pkg::CS_EXEC;
        end
      end
      tmq_pkg::CS_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.recv_scan ? tmq_pkg::CS_SCAN : tmq_pkg::CS_DONE;
      end
      tmq_pkg::CS_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = tmq_pkg::CS_DECIDE;
        end
      end
      tmq_pkg::CS_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = sts_i.shift_go ? tmq_pkg::CS_SHIFT : tmq_pkg::CS_DONE;
      end
      tmq_pkg::CS_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_done) begin
          state_d = tmq_pkg::CS_DONE;
        end
      end
      tmq_pkg::CS_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = tmq_pkg::CS_IDLE;
        end
      end
      default: state_d = tmq_pkg::CS_IDLE;
    endcase
  end

  // Output valid sets on a load and clears when the item is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.load_out)
    else $error("result loaded over a waiting item");

  // The scan is only entered from request execution.
  a_scan_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tmq_pkg::CS_SCAN) |->
      ($past(state_q) == tmq_pkg::CS_EXEC || $past(state_q) == tmq_pkg::CS_SCAN))
    else $error("scan entered out of sequence");

endmodule

// ===== src/tmq_datapath.sv =====
module tmq_datapath #(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned MAX_MSG_BYTES = 8192
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tmq_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [tmq_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  tmq_pkg::req_t                     in_data_i,
  output tmq_pkg::rsp_t                     out_data_o,
  input  tmq_pkg::ctrl_cmd_t                cmd_i,
  output tmq_pkg::dp_sts_t                  sts_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // Configuration registers.
  logic [15:0] byte_limit_q;
  logic [13:0] max_size_q;

  // Queue state.
  logic [CW-1:0] cnt_q, cnt_d;
  logic [15:0]   bytes_q, bytes_d;

  // Latched request and result fields.
  tmq_pkg::req_t    req_q;
  tmq_pkg::status_e res_status_q, res_status_d;
  logic [30:0]      res_type_q, res_type_d;
  logic [13:0]      res_size_q, res_size_d;
  logic [15:0]      res_handle_q, res_handle_d;
  tmq_pkg::rsp_t    out_q;

  // Scan and shift state.
  logic [AW-1:0]   scan_idx_q, scan_idx_d;
  logic [AW-1:0]   shift_idx_q, shift_idx_d;
  logic            found_q, found_d;
  tmq_pkg::entry_t best_q, best_d;
  logic [AW-1:0]   best_idx_q, best_idx_d;

  // Message store.
  tmq_pkg::entry_t mem [QUEUE_DEPTH];
  tmq_pkg::entry_t rd_data_q;
  tmq_pkg::entry_t wr_data;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic            wr_en;

  // Helper values.
  logic [AW-1:0] last_idx;
  logic [31:0]   want_mag;
  logic [31:0]   ent_type_ext;
  logic          hit;
  logic          want_neg, want_zero;
  logic          big;

  assign last_idx     = cnt_q[AW-1:0] - AW'(1);
  assign want_neg     = req_q.want_type[31];
  assign want_zero    = (req_q.want_type == '0);
  assign want_mag     = 32'd0 - $unsigned(req_q.want_type);
  assign ent_type_ext = {1'b0, rd_data_q.msg_type};
  assign big          = {2'b00, best_q.size} > req_q.msg_size;

  // Match test for the entry read in the previous cycle.
  always_comb begin
    if (want_zero) begin
      hit = 1'b1;
    end else if (!want_neg) begin
      hit = (ent_type_ext == $unsigned(req_q.want_type));
    end else begin
      hit = (ent_type_ext <= want_mag) &&
            (!found_q || (rd_data_q.msg_type < best_q.msg_type));
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_limit_q <= tmq_pkg::QUEUE_BYTE_LIMIT_RST;
      max_size_q   <= tmq_pkg::MAX_MESSAGE_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        tmq_pkg::CFG_QUEUE_BYTE_LIMIT: byte_limit_q <= cfg_wdata_i;
        tmq_pkg::CFG_MAX_MESSAGE_SIZE: max_size_q   <= cfg_wdata_i[13:0];
        default: ;
      endcase
    end
  end

  // Queue count and byte total.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      bytes_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      bytes_q <= bytes_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_data_i;
    end
    if (cmd_i.load_out) begin
      out_q <= '{status:      res_status_q,
                 out_type:    res_type_q,
                 out_size:    res_size_q,
                 out_handle:  res_handle_q,
                 queue_count: 5'(cnt_q),
                 queue_bytes: bytes_q};
    end
    res_status_q <= res_status_d;
    res_type_q   <= res_type_d;
    res_size_q   <= res_size_d;
    res_handle_q <= res_handle_d;
    scan_idx_q   <= scan_idx_d;
    shift_idx_q  <= shift_idx_d;
    found_q      <= found_d;
    best_q       <= best_d;
    best_idx_q   <= best_idx_d;
  end

  // Message store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  // Request execution, scan, decision and compaction.
  always_comb begin
    cnt_d        = cnt_q;
    bytes_d      = bytes_q;
    res_status_d = res_status_q;
    res_type_d   = res_type_q;
    res_size_d   = res_size_q;
    res_handle_d = res_handle_q;
    scan_idx_d   = scan_idx_q;
    shift_idx_d  = shift_idx_q;
    found_d      = found_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = cnt_q[AW-1:0];
    wr_data      = '{msg_type: req_q.send_type,
                     size:     req_q.msg_size[13:0],
                     handle:   req_q.payload_handle};
    sts_o        = '0;

    if (cmd_i.exec) begin
      res_type_d   = '0;
      res_size_d   = '0;
      res_handle_d = '0;
      unique case (req_q.req_type)
        tmq_pkg::REQ_SEND: begin
          if ((req_q.msg_size > {2'b00, max_size_q}) ||
              ({1'b0, req_q.msg_size} > 17'(MAX_MSG_BYTES)) ||
              (req_q.send_type == '0)) begin
            res_status_d = tmq_pkg::STS_INVALID;
          end else if (({1'b0, bytes_q} + {1'b0, req_q.msg_size}) >
                       {1'b0, byte_limit_q}) begin
            res_status_d = tmq_pkg::STS_AGAIN;
          end else if (cnt_q >= CW'(QUEUE_DEPTH)) begin
            res_status_d = tmq_pkg::STS_AGAIN;
          end else begin
            res_status_d = tmq_pkg::STS_OK;
            wr_en        = 1'b1;
            cnt_d        = cnt_q + CW'(1);
            bytes_d      = bytes_q + req_q.msg_size;
          end
        end
        tmq_pkg::REQ_RECV: begin
          if (cnt_q == '0) begin
            res_status_d = tmq_pkg::STS_NOMSG;
          end else begin
            sts_o.recv_scan = 1'b1;
            scan_idx_d      = '0;
            found_d         = 1'b0;
            rd_addr         = '0;
          end
        end
        tmq_pkg::REQ_FLUSH: begin
          res_status_d = tmq_pkg::STS_OK;
          cnt_d        = '0;
          bytes_d      = '0;
        end
        default: res_status_d = tmq_pkg::STS_INVALID;
      endcase
    end

    // One entry per cycle; exact and any selectors stop at the first hit.
    if (cmd_i.scan) begin
      if (hit) begin
        found_d    = 1'b1;
        best_d     = rd_data_q;
        best_idx_d = scan_idx_q;
      end
      sts_o.scan_done = (hit && !want_neg) || (scan_idx_q == last_idx);
      if (!sts_o.scan_done) begin
        scan_idx_d = scan_idx_q + AW'(1);
        rd_addr    = scan_idx_q + AW'(1);
      end
    end

    // Remove or refuse the chosen message.
    if (cmd_i.decide) begin
      if (!found_q) begin
        res_status_d = tmq_pkg::STS_NOMSG;
      end else if (big && !req_q.allow_truncate) begin
        res_status_d = tmq_pkg::STS_TOOBIG;
      end else begin
        res_status_d = tmq_pkg::STS_OK;
        res_type_d   = best_q.msg_type;
        res_size_d   = big ? req_q.msg_size[13:0] : best_q.size;
        res_handle_d = best_q.handle;
        cnt_d        = cnt_q - CW'(1);
        bytes_d      = ({2'b00, best_q.size} <= bytes_q) ?
                       (bytes_q - {2'b00, best_q.size}) : '0;
        if (best_idx_q != last_idx) begin
          sts_o.shift_go = 1'b1;
          shift_idx_d    = best_idx_q + AW'(1);
          rd_addr        = best_idx_q + AW'(1);
        end
      end
    end

    // Compaction: each entry after the removed one moves down by one.
    if (cmd_i.shift) begin
      wr_en            = 1'b1;
      wr_addr          = shift_idx_q - AW'(1);
      wr_data          = rd_data_q;
      sts_o.shift_done = (shift_idx_q == cnt_q[AW-1:0]);
      if (!sts_o.shift_done) begin
        shift_idx_d = shift_idx_q + AW'(1);
        rd_addr     = shift_idx_q + AW'(1);
      end
    end
  end

  assign out_data_o = out_q;

  // The count never passes the store depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // An empty queue holds no bytes.
  a_empty_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (bytes_q == '0))
    else $error("bytes on an empty queue");

  // Compaction writes stay inside the remaining entries.
  a_shift_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift |-> ((CW + 1)'(wr_addr) < (CW + 1)'(cnt_q)))
    else $error("compaction write beyond the queue");

endmodule
